// ----- rtl/core/sort_points_by_origin_distance_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the waypoint distance sorter
// Clocked concurrent checks with reset disable; compiled out by ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef SORT_POINTS_BY_ORIGIN_DISTANCE_CORE_ASSERT_SVH
`define SORT_POINTS_BY_ORIGIN_DISTANCE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define SOPD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sopd assertion failed");
`define SOPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sopd sequence assertion failed");
`else
`define SOPD_ASSERT(lbl, clk, rstn, prop)
`define SOPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/core/sopd_pkg.sv -----
// ----------------------------------------------------------------------------
// sopd_pkg
// Shared widths, sequencer states and payload types of the distance sorter.
// ----------------------------------------------------------------------------
package sopd_pkg;

    localparam int MAX_POINTS_DEF = 8;
    localparam int COORD_W        = 16;
    localparam int KEY_W          = 33;
    localparam int SRC_W          = 3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_KW,
        S_KI,
        S_KIW,
        S_OA,
        S_OW,
        S_KC,
        S_WR,
        S_EO,
        S_EP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic en;
        logic clr;
    } t_sq_ctrl;

    typedef struct packed {
        logic signed [COORD_W-1:0] sorted_x;
        logic signed [COORD_W-1:0] sorted_y;
        logic [SRC_W-1:0]          source_index;
        logic                      run_end;
    } t_result;

endpackage

// ----- rtl/core/sopd_in_if.sv -----
// ----------------------------------------------------------------------------
// sopd_in_if
// Waypoint input channel: valid/ready with one coordinate pair per transfer.
// ----------------------------------------------------------------------------
interface sopd_in_if
    import sopd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      final_point;

    modport source (output valid, output point_x, output point_y, output final_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input final_point,
                    output ready);
endinterface

// ----- rtl/core/sopd_out_if.sv -----
// ----------------------------------------------------------------------------
// sopd_out_if
// Sorted waypoint output channel: valid/ready with one waypoint per transfer.
// ----------------------------------------------------------------------------
interface sopd_out_if
    import sopd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] sorted_x;
    logic signed [COORD_W-1:0] sorted_y;
    logic [SRC_W-1:0]          source_index;
    logic                      run_end;

    modport source (output valid, output sorted_x, output sorted_y,
                    output source_index, output run_end, input ready);
    modport sink   (input valid, input sorted_x, input sorted_y,
                    input source_index, input run_end, output ready);
endinterface

// ----- rtl/core/sort_points_by_origin_distance_core.sv -----
// ----------------------------------------------------------------------------
// sort_points_by_origin_distance_core
// Loads waypoints, sorts them by squared distance from the origin, emits them.
// ----------------------------------------------------------------------------
//  channel  | dir | transfer payload
//  i_pt     | in  | point_x, point_y, final_point
//  o_sort   | out | sorted_x, sorted_y, source_index, run_end
//
//  Load: a stored waypoint takes transfer, square x, square y, key write;
//  a dropped waypoint takes the transfer only. x and y share one squarer.
//  Sort: per waypoint i, a key read; per compared entry, order and key reads
//  and a compare; then the order write. Emit: each result passes the order
//  and point store reads. Reset is synchronous; the stores hold no reset.
//  o_sort stalls hold the result register and the sequencer.
// ----------------------------------------------------------------------------
module sort_points_by_origin_distance_core
    import sopd_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sopd_in_if.sink     i_pt,
    sopd_out_if.source  o_sort
);

    logic    w_emit;
    logic    w_out_free;
    t_result w_res;
    t_result r_res;
    logic    r_valid;

    assign w_out_free = !r_valid || o_sort.ready;

    sopd_engine #(
        .MaxPoints (MAX_POINTS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_pt.valid),
        .o_ready    (i_pt.ready),
        .i_x        (i_pt.point_x),
        .i_y        (i_pt.point_y),
        .i_last     (i_pt.final_point),
        .i_out_free (w_out_free),
        .o_emit     (w_emit),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_emit) begin
            r_valid <= 1'b1;
        end else if (o_sort.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_res <= w_res;
        end
    end

    assign o_sort.valid        = r_valid;
    assign o_sort.sorted_x     = r_res.sorted_x;
    assign o_sort.sorted_y     = r_res.sorted_y;
    assign o_sort.source_index = r_res.source_index;
    assign o_sort.run_end      = r_res.run_end;

endmodule

// ----- rtl/core/sopd_square.sv -----
// ----------------------------------------------------------------------------
// sopd_square
// Shared square-and-accumulate unit: one signed 16x16 square per cycle of en.
// ----------------------------------------------------------------------------
module sopd_square
    import sopd_pkg::*;
(
    input  logic                      i_clk,
    input  t_sq_ctrl                  i_ctrl,
    input  logic signed [COORD_W-1:0] i_op,
    output logic [KEY_W-1:0]          o_acc
);

    logic signed [2*COORD_W-1:0] w_sq;
    logic [KEY_W-1:0]            r_acc;
    logic [KEY_W-1:0]            n_acc;

    assign w_sq  = i_op * i_op;
    assign n_acc = (i_ctrl.clr ? '0 : r_acc) + KEY_W'(unsigned'(w_sq));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- rtl/core/sopd_engine.sv -----
// ----------------------------------------------------------------------------
// sopd_engine
// Load sequencer, stores and stable insertion sort over the squared distances.
// ----------------------------------------------------------------------------
`include "sort_points_by_origin_distance_core_assert.svh"

module sopd_engine
    import sopd_pkg::*;
#(
    parameter int MaxPoints = MAX_POINTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_y,
    input  logic                      i_last,
    input  logic                      i_out_free,
    output logic                      o_emit,
    output t_result                   o_res
);

    localparam int IW = $clog2(MaxPoints);
    localparam int CW = $clog2(MaxPoints + 1);

    t_state r_state;
    t_state n_state;

    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_i;
    logic [CW-1:0]             r_j;
    logic [CW-1:0]             r_k;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic                      r_last;
    logic [KEY_W-1:0]          r_key;
    logic [IW-1:0]             r_oidx;

    logic [2*COORD_W-1:0] pt_mem [MaxPoints];
    logic [KEY_W-1:0]     key_mem [MaxPoints];
    logic [IW-1:0]        ord_mem [MaxPoints];

    logic [2*COORD_W-1:0] r_pt_rd;
    logic [KEY_W-1:0]     r_key_rd;
    logic [IW-1:0]        r_ord_rd;

    logic          w_accept;
    logic          w_full;
    logic          w_greater;
    logic          w_emit;
    logic          pt_we;
    logic          pt_re;
    logic [IW-1:0] pt_ra;
    logic          key_we;
    logic          key_re;
    logic [IW-1:0] key_ra;
    logic          ord_re;
    logic [IW-1:0] ord_ra;
    logic          ord_we;
    logic [IW-1:0] ord_wa;
    logic [IW-1:0] ord_wd;
    t_sq_ctrl      sq_ctrl;
    logic signed [COORD_W-1:0] sq_op;
    logic [KEY_W-1:0]          sq_acc;

    assign w_full    = (r_count == CW'(MaxPoints));
    assign w_accept  = i_valid && o_ready;
    assign w_greater = (r_key_rd > r_key);

    sopd_square u_square (
        .i_clk  (i_clk),
        .i_ctrl (sq_ctrl),
        .i_op   (sq_op),
        .o_acc  (sq_acc)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!w_full) begin
                        n_state = S_SQX;
                    end else if (i_last) begin
                        n_state = S_KI;
                    end
                end
            end
            S_SQX: n_state = S_SQY;
            S_SQY: n_state = S_KW;
            S_KW:  n_state = r_last ? S_KI : S_IDLE;
            S_KI:  n_state = S_KIW;
            S_KIW: n_state = (r_i == '0) ? S_WR : S_OA;
            S_OA:  n_state = S_OW;
            S_OW:  n_state = S_KC;
            S_KC: begin
                if (w_greater && r_j != CW'(1)) begin
                    n_state = S_OA;
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR:  n_state = ((r_i + CW'(1)) == r_count) ? S_EO : S_KI;
            S_EO:  n_state = S_EP;
            S_EP:  n_state = S_OUT;
            S_OUT: begin
                if (i_out_free) begin
                    n_state = ((r_k + CW'(1)) == r_count) ? S_IDLE : S_EO;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = 1'b0;
        pt_we   = 1'b0;
        pt_re   = 1'b0;
        pt_ra   = r_ord_rd;
        key_we  = 1'b0;
        key_re  = 1'b0;
        key_ra  = r_i[IW-1:0];
        ord_re  = 1'b0;
        ord_ra  = r_k[IW-1:0];
        ord_we  = 1'b0;
        ord_wa  = r_j[IW-1:0];
        ord_wd  = r_i[IW-1:0];
        sq_ctrl = '{en: 1'b0, clr: 1'b0};
        sq_op   = r_x;
        w_emit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                pt_we   = i_valid && !w_full;
            end
            S_SQX: sq_ctrl = '{en: 1'b1, clr: 1'b1};
            S_SQY: begin
                sq_ctrl = '{en: 1'b1, clr: 1'b0};
                sq_op   = r_y;
            end
            S_KW:  key_we = 1'b1;
            S_KI:  key_re = 1'b1;
            S_OA: begin
                ord_re = 1'b1;
                ord_ra = IW'(r_j - CW'(1));
            end
            S_OW: begin
                key_re = 1'b1;
                key_ra = r_ord_rd;
            end
            S_KC: begin
                ord_we = w_greater;
                ord_wd = r_oidx;
            end
            S_WR:  ord_we = 1'b1;
            S_EO:  ord_re = 1'b1;
            S_EP:  pt_re  = 1'b1;
            S_OUT: w_emit = i_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_KW) begin
                r_count <= r_count + CW'(1);
            end else if (w_emit && (r_k + CW'(1)) == r_count) begin
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept) begin
            r_x    <= i_x;
            r_y    <= i_y;
            r_last <= i_last;
            r_i    <= '0;
        end
        unique case (r_state)
            S_KI:  r_j <= r_i;
            S_KIW: r_key <= r_key_rd;
            S_OW:  r_oidx <= r_ord_rd;
            S_KC: begin
                if (w_greater) begin
                    r_j <= r_j - CW'(1);
                end
            end
            S_WR: begin
                r_i <= r_i + CW'(1);
                r_k <= '0;
            end
            S_EP:  r_oidx <= r_ord_rd;
            S_OUT: begin
                if (w_emit) begin
                    r_k <= r_k + CW'(1);
                end
            end
            default: ;
        endcase
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            pt_mem[r_count[IW-1:0]] <= {i_y, i_x};
        end
        if (pt_re) begin
            r_pt_rd <= pt_mem[pt_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[r_count[IW-1:0]] <= sq_acc;
        end
        if (key_re) begin
            r_key_rd <= key_mem[key_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            ord_mem[ord_wa] <= ord_wd;
        end
        if (ord_re) begin
            r_ord_rd <= ord_mem[ord_ra];
        end
    end

    assign o_emit             = w_emit;
    assign o_res.sorted_x     = r_pt_rd[COORD_W-1:0];
    assign o_res.sorted_y     = r_pt_rd[2*COORD_W-1:COORD_W];
    assign o_res.source_index = SRC_W'(r_oidx);
    assign o_res.run_end      = ((r_k + CW'(1)) == r_count);

    `SOPD_ASSERT(a_emit_free, i_clk, i_rst_n, w_emit |-> i_out_free)
    `SOPD_ASSERT(a_count_cap, i_clk, i_rst_n, r_count <= CW'(MaxPoints))
    `SOPD_ASSERT_NEXT(a_last_sorts, i_clk, i_rst_n, (r_state == S_KW) && r_last, r_state == S_KI)
    `SOPD_ASSERT(a_insert_range, i_clk, i_rst_n, (r_state == S_WR) |-> (r_i < r_count))

endmodule

// ----- sim/sort_points_by_origin_distance_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_points_by_origin_distance_core_tb
// Loads waypoint sets through the input channel and checks every sorted
// waypoint against a stable sort on squared distance kept in the bench.
// A directed table covers coordinate extremes, distance ties, a reversed pair
// and a full store with dropped waypoints. Random sets follow, with random
// idle cycles on both channels and one stretch without idle cycles.
// ----------------------------------------------------------------------------
module sort_points_by_origin_distance_core_tb;
    import sopd_pkg::*;

    localparam int STORE_DEPTH  = MAX_POINTS_DEF;
    localparam int IDLE_PCT     = 26;
    localparam int RANDOM_ITEMS = 196;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 300;
    localparam int NUM_ROWS     = 24;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
        logic                      known;
        t_result                   exp;
    } t_waypoint_row;

    localparam t_waypoint_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{16'sh8000, 16'sh8000, 1'b1, 1'b1, '{16'sh8000, 16'sh8000, 3'd0, 1'b1}},
        '{16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, '{16'sh7FFF, 16'sh7FFF, 3'd0, 1'b1}},
        '{16'sd0,    16'sd0,    1'b1, 1'b1, '{16'sd0,    16'sd0,    3'd0, 1'b1}},
        '{16'sh7FFF, 16'sh8000, 1'b1, 1'b1, '{16'sh7FFF, 16'sh8000, 3'd0, 1'b1}},
        '{16'sd3,    16'sd4,    1'b0, 1'b0, '0},
        '{-16'sd4,   16'sd3,    1'b0, 1'b0, '0},
        '{16'sd5,    16'sd0,    1'b0, 1'b0, '0},
        '{16'sd0,    -16'sd5,   1'b0, 1'b0, '0},
        '{16'sh8000, 16'sd0,    1'b0, 1'b0, '0},
        '{16'sd0,    16'sd0,    1'b0, 1'b0, '0},
        '{16'sd1,    16'sd1,    1'b0, 1'b0, '0},
        '{16'sh7FFF, 16'sh8000, 1'b1, 1'b0, '0},
        '{16'sd100,  16'sd0,    1'b0, 1'b0, '0},
        '{16'sd1,    16'sd0,    1'b1, 1'b0, '0},
        '{-16'sd1,   -16'sd1,   1'b0, 1'b0, '0},
        '{16'sd2,    -16'sd2,   1'b0, 1'b0, '0},
        '{16'sh8000, 16'sh8000, 1'b0, 1'b0, '0},
        '{-16'sd3,   16'sd0,    1'b0, 1'b0, '0},
        '{16'sd0,    16'sd3,    1'b0, 1'b0, '0},
        '{16'sh7FFF, 16'sd0,    1'b0, 1'b0, '0},
        '{-16'sd1,   16'sd1,    1'b0, 1'b0, '0},
        '{16'sd1,    -16'sd1,   1'b0, 1'b0, '0},
        '{16'sd5,    16'sd5,    1'b0, 1'b0, '0},
        '{16'sd6,    16'sd6,    1'b1, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    sopd_in_if  pt_ch ();
    sopd_out_if sort_ch ();

    sort_points_by_origin_distance_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_ch),
        .o_sort  (sort_ch)
    );

    logic signed [COORD_W-1:0] held_x [STORE_DEPTH];
    logic signed [COORD_W-1:0] held_y [STORE_DEPTH];
    logic [KEY_W-1:0]          held_key [STORE_DEPTH];
    int                        held_count = 0;

    t_result pending_waypoints [$];
    int      idle_pct = IDLE_PCT;
    int      mismatches = 0;
    int      cycle_count = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Hold the waypoint, and on the closing one emit the stable distance order.
    task automatic sort_waypoint(input logic signed [COORD_W-1:0] x,
                                 input logic signed [COORD_W-1:0] y,
                                 input logic last, input bit publish);
        int      slot [STORE_DEPTH];
        int      j;
        t_result r;
        if (held_count < STORE_DEPTH) begin
            held_x[held_count]   = x;
            held_y[held_count]   = y;
            held_key[held_count] = KEY_W'(longint'(x) * longint'(x) + longint'(y) * longint'(y));
            held_count++;
        end
        if (last) begin
            for (int i = 0; i < held_count; i++) begin
                j = i;
                while (j > 0 && held_key[slot[j-1]] > held_key[i]) begin
                    slot[j] = slot[j-1];
                    j--;
                end
                slot[j] = i;
            end
            if (publish) begin
                for (int k = 0; k < held_count; k++) begin
                    r.sorted_x     = held_x[slot[k]];
                    r.sorted_y     = held_y[slot[k]];
                    r.source_index = SRC_W'(slot[k]);
                    r.run_end      = (k == held_count - 1);
                    pending_waypoints.push_back(r);
                end
            end
            held_count = 0;
        end
    endtask

    task automatic transfer_point(input logic signed [COORD_W-1:0] x,
                                  input logic signed [COORD_W-1:0] y,
                                  input logic last);
        while ($urandom_range(99) < idle_pct) begin
            pt_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_ch.valid       <= 1'b1;
        pt_ch.point_x     <= x;
        pt_ch.point_y     <= y;
        pt_ch.final_point <= last;
        @(posedge i_clk);
        while (!pt_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) return COORD_W'($urandom);
        if (pick < 70) return COORD_W'(int'($urandom_range(8)) - 4);
        if (pick < 85) begin
            case ($urandom_range(4))
                0: return 16'sh8000;
                1: return 16'sh7FFF;
                2: return 16'sh8001;
                3: return -16'sd1;
                default: return 16'sd0;
            endcase
        end
        return COORD_W'($urandom_range(16'hFFFF, 16'hFF00));
    endfunction

    always @(posedge i_clk) begin : sorted_monitor
        t_result got;
        t_result want;
        if (i_rst_n && sort_ch.valid && sort_ch.ready) begin
            got = '{sort_ch.sorted_x, sort_ch.sorted_y, sort_ch.source_index,
                    sort_ch.run_end};
            if (pending_waypoints.size() == 0) begin
                $display("%0t unexpected waypoint x=%0d y=%0d idx=%0d end=%0b", $time,
                         got.sorted_x, got.sorted_y, got.source_index, got.run_end);
                mismatches++;
            end else begin
                want = pending_waypoints.pop_front();
                if (got.sorted_x !== want.sorted_x) begin
                    $display("%0t sorted_x expected %0d actual %0d", $time,
                             want.sorted_x, got.sorted_x);
                    mismatches++;
                end
                if (got.sorted_y !== want.sorted_y) begin
                    $display("%0t sorted_y expected %0d actual %0d", $time,
                             want.sorted_y, got.sorted_y);
                    mismatches++;
                end
                if (got.source_index !== want.source_index) begin
                    $display("%0t source_index expected %0d actual %0d", $time,
                             want.source_index, got.source_index);
                    mismatches++;
                end
                if (got.run_end !== want.run_end) begin
                    $display("%0t run_end expected %0b actual %0b", $time,
                             want.run_end, got.run_end);
                    mismatches++;
                end
            end
        end
        sort_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    initial begin : stimulus
        int                        items_sent;
        int                        set_no;
        int                        set_len;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
        t_waypoint_row             row;
        items_sent = 0;
        set_no     = 0;
        i_rst_n           <= 1'b0;
        pt_ch.valid       <= 1'b0;
        pt_ch.point_x     <= '0;
        pt_ch.point_y     <= '0;
        pt_ch.final_point <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            row = DIRECTED_ROWS[r];
            transfer_point(row.x, row.y, row.last);
            sort_waypoint(row.x, row.y, row.last, !row.known);
            if (row.known) pending_waypoints.push_back(row.exp);
        end

        while (items_sent < RANDOM_ITEMS) begin
            set_len  = ($urandom_range(9) == 0) ? $urandom_range(11, 9) : $urandom_range(8, 1);
            idle_pct = (set_no >= 12 && set_no < 20) ? 0 : IDLE_PCT;
            for (int k = 0; k < set_len; k++) begin
                x    = rand_coord();
                y    = rand_coord();
                last = (k == set_len - 1);
                transfer_point(x, y, last);
                sort_waypoint(x, y, last, 1'b1);
                items_sent++;
            end
            set_no++;
        end
        pt_ch.valid <= 1'b0;
        idle_pct = IDLE_PCT;

        while (pending_waypoints.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
